// ----- design/tft_pkg.sv -----
// Shared constants, types and helpers of the transfer-function table.
`default_nettype none
package tft_pkg;

    localparam int MAX_NODES          = 16;
    localparam int MAIN_MAP_WIDTH     = 128;
    localparam int EMISSIVE_MAP_WIDTH = 64;

    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);

    localparam logic [6:0] MAIN_WM1 = 7'(MAIN_MAP_WIDTH - 1);
    localparam logic [6:0] EMIS_WM1 = 7'(EMISSIVE_MAP_WIDTH - 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] MAP_DIFFUSE  = 2'd0;
    localparam logic [1:0] MAP_SPECULAR = 2'd1;
    localparam logic [1:0] MAP_OPACITY  = 2'd2;
    localparam logic [1:0] MAP_EMISSIVE = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // ln 2 in Q0.32 and ceil(2^39 / 255) for exact division by 255
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [31:0] RECIP_255 = 32'd2155905153;

    typedef logic [NODE_AW-1:0] t_addr;
    typedef logic [CNT_W-1:0]   t_count;

    typedef struct packed {
        logic [16:0] density;
        logic [23:0] diffuse_rgb;
        logic [23:0] specular_rgb;
        logic [23:0] emissive_rgb;
        logic [7:0]  gloss_level;
        logic [15:0] emissive_strength;
        logic [15:0] optical_thickness;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_LK_RD,
        S_LK_CHK,
        S_FRAC,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_LOG,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        L_IDLE,
        L_NORM,
        L_SQR,
        L_SCALE,
        L_DONE
    } t_ln_state;

    // map position of a node: floor(d * (W - 1) / 65536), clamped to W - 1
    function automatic logic [6:0] span_pos(input logic [16:0] d, input logic [6:0] wm1);
        logic [23:0] prod;
        logic [7:0]  x;
        prod = 24'(d) * 24'(wm1);
        x    = prod[23:16];
        return (x > {1'b0, wm1}) ? wm1 : x[6:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/tft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- design/tft_nlog.sv -----
// Iterative -ln(1 - t) unit: normalize, sixteen squarings, scale by ln 2.
`default_nettype none
module tft_nlog import tft_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_t,
    output logic             o_done,
    output logic [15:0]      o_alpha
);

    t_ln_state   r_state, n_state;
    logic [32:0] r_nm;
    logic [5:0]  r_k;
    logic [31:0] r_m;
    logic [15:0] r_frac;
    logic [3:0]  r_cnt;
    logic [53:0] r_prod;

    logic [63:0] sq;
    logic [32:0] sq_sh;
    logic [21:0] neg;

    assign sq    = 64'(r_m) * 64'(r_m);
    assign sq_sh = sq[63:31];
    assign neg   = 22'(32 * 65536) - {r_k, r_frac};

    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE:  if (i_start) n_state = L_NORM;
            L_NORM:  if (r_nm[32]) n_state = L_SQR;
            L_SQR:   if (r_cnt == 4'd15) n_state = L_SCALE;
            L_SCALE: n_state = L_DONE;
            L_DONE:  n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_comb begin
        o_done  = (r_state == L_DONE);
        o_alpha = {2'b00, r_prod[53:40]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_nm   <= 33'h1_0000_0000 - {1'b0, i_t};
                r_k    <= 6'd32;
                r_cnt  <= '0;
                r_frac <= '0;
            end
            L_NORM: begin
                // shift the leading one up to bit 32
                if (r_nm[32]) begin
                    r_m <= r_nm[32:1];
                end else begin
                    r_nm <= {r_nm[31:0], 1'b0};
                    r_k  <= r_k - 6'd1;
                end
            end
            L_SQR: begin
                if (sq_sh[32]) begin
                    r_m    <= sq_sh[32:1];
                    r_frac <= {r_frac[14:0], 1'b1};
                end else begin
                    r_m    <= sq_sh[31:0];
                    r_frac <= {r_frac[14:0], 1'b0};
                end
                r_cnt <= r_cnt + 4'd1;
            end
            L_SCALE: r_prod <= 54'(neg) * 54'(LN2_Q32);
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/transfer_function_table.sv -----
// Top level of the transfer-function table: node store, lookup sequencer, result port.
`default_nettype none
// The block keeps up to sixteen transfer-function nodes sorted by density in one
// synchronous RAM and works on one item at a time: start is taken while busy is low,
// and exactly one result follows as a single-cycle o_strobe that cannot be held off.
// Clear, an ignored operation code, an insert into a full table, a lookup beyond
// its map and a lookup with fewer than two nodes answer in the cycle after the item
// is taken. An insert walks the RAM down from the top, reading a node in S_INS_RD and
// moving it up in S_INS_CHK while it is denser than the new one, then writes the new
// node. A lookup reads every stored node once, then forms the fraction, runs the
// bit-serial divider when the entry lies strictly inside its span, multiplies in
// S_MUL1 to S_MUL3, and for the opacity map then lets the log unit normalize, square
// and scale by ln 2 before the result is handed back.
module transfer_function_table import tft_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [16:0] i_density,
    input  wire logic [23:0] i_diffuse_rgb,
    input  wire logic [23:0] i_specular_rgb,
    input  wire logic [23:0] i_emissive_rgb,
    input  wire logic [7:0]  i_gloss_level,
    input  wire logic [15:0] i_emissive_strength,
    input  wire logic [15:0] i_optical_thickness,
    input  wire logic [1:0]  i_map_select,
    input  wire logic [6:0]  i_entry_index,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [15:0]      o_chan_red,
    output logic [15:0]      o_chan_green,
    output logic [15:0]      o_chan_blue,
    output logic [15:0]      o_chan_alpha
);

    t_state  r_state, n_state;
    t_count  r_count;
    logic    r_strobe;

    // item registers
    t_node       r_new;
    logic [1:0]  r_sel;
    logic [6:0]  r_idx;
    logic [6:0]  r_wm1;

    // walk registers
    t_count      r_j;
    t_node       r_prev;
    logic [6:0]  r_prev_x;
    t_node       r_lo;
    t_node       r_hi;
    logic        r_found;

    // fraction and lanes
    logic [24:0] r_rem;
    logic [23:0] r_den;
    logic [16:0] r_p;
    logic [3:0]  r_cnt;
    logic [23:0] r_a1 [4];
    logic [23:0] r_a2 [4];
    logic [41:0] r_x  [4];
    logic [55:0] r_y  [3];

    // result registers
    logic [1:0]  r_status;
    logic [15:0] r_red, r_green, r_blue, r_alpha;

    // RAM port
    logic        ram_we;
    t_addr       ram_waddr, ram_raddr;
    t_node       ram_wdata, ram_rdata;

    logic        ln_start, ln_done;
    logic [15:0] ln_alpha;

    logic        accept;
    logic        emit;
    logic [1:0]  n_status;
    logic [15:0] n_red, n_green, n_blue, n_alpha;

    logic [6:0]  in_wm1;
    logic        in_range_err;
    logic [6:0]  cur_x;
    logic        hit_now;
    logic        last_node;
    logic        shift_up;
    logic [25:0] num;
    logic [23:0] den;
    logic        frac_zero, frac_full;
    logic [24:0] div_sh;
    logic        div_bit;
    logic [16:0] q;

    tft_ram #(
        .WIDTH(NODE_W),
        .DEPTH(MAX_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tft_nlog u_nlog (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ln_start),
        .i_t     (r_x[3][31:0]),
        .o_done  (ln_done),
        .o_alpha (ln_alpha)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign in_wm1       = (i_map_select == MAP_EMISSIVE) ? EMIS_WM1 : MAIN_WM1;
    assign in_range_err = (i_map_select == MAP_EMISSIVE) ?
                          (32'(i_entry_index) >= EMISSIVE_MAP_WIDTH) :
                          (32'(i_entry_index) >= MAIN_MAP_WIDTH);

    // walk: pair (j-1, j) covers the entry when prev_x <= idx <= x
    assign cur_x     = span_pos(ram_rdata.density, r_wm1);
    assign hit_now   = (r_j != '0) && (r_prev_x <= r_idx) && (r_idx <= cur_x);
    assign last_node = (r_j == r_count - t_count'(1));

    // insert: move the read node up while it is denser than the new one
    assign shift_up = (ram_rdata.density > r_new.density);

    // fraction numerator and denominator
    assign num       = {3'b000, r_idx, 16'h0000}
                     - {2'b00, 24'(24'(r_lo.density) * 24'(r_wm1))};
    assign den       = 24'(24'(r_hi.density - r_lo.density) * 24'(r_wm1));
    assign frac_zero = num[25] || (num == '0);
    assign frac_full = (num[24:0] >= {1'b0, den});

    assign div_sh  = {r_rem[23:0], 1'b0};
    assign div_bit = (div_sh >= {1'b0, r_den});
    assign q       = 17'h10000 - r_p;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_INSERT:
                            if (r_count < t_count'(MAX_NODES)) n_state = S_INS_RD;
                        OP_LOOKUP:
                            if (!in_range_err && r_count >= t_count'(2)) n_state = S_LK_RD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_RD:  n_state = (r_j == '0) ? S_IDLE : S_INS_CHK;
            S_INS_CHK: n_state = shift_up ? S_INS_RD : S_IDLE;
            S_LK_RD:   n_state = S_LK_CHK;
            S_LK_CHK: begin
                if (last_node) begin
                    n_state = (hit_now || r_found) ? S_FRAC : S_IDLE;
                end
            end
            S_FRAC:  n_state = (!frac_zero && !frac_full) ? S_DIV : S_MUL1;
            S_DIV:   if (r_cnt == 4'd15) n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = (r_sel == MAP_OPACITY) ? S_LOG : S_FIN;
            S_LOG:   if (ln_done) n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // RAM control, log start and result selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_j[NODE_AW-1:0];
        ram_wdata = r_new;
        ram_raddr = '0;
        ln_start  = 1'b0;
        emit      = 1'b0;
        n_status  = ST_DONE;
        n_red     = '0;
        n_green   = '0;
        n_blue    = '0;
        n_alpha   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_INSERT: begin
                            if (r_count >= t_count'(MAX_NODES)) begin
                                emit     = 1'b1;
                                n_status = ST_FULL;
                            end
                        end
                        OP_LOOKUP: begin
                            if (in_range_err) begin
                                emit     = 1'b1;
                                n_status = ST_RANGE;
                            end else if (r_count < t_count'(2)) begin
                                emit = 1'b1;
                            end
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_j == '0) begin
                    ram_we = 1'b1;
                    emit   = 1'b1;
                end else begin
                    ram_raddr = NODE_AW'(r_j - t_count'(1));
                end
            end
            S_INS_CHK: begin
                ram_we    = 1'b1;
                ram_wdata = shift_up ? ram_rdata : r_new;
                emit      = !shift_up;
            end
            S_LK_RD:  ram_raddr = '0;
            S_LK_CHK: begin
                ram_raddr = NODE_AW'(r_j + t_count'(1));
                emit      = last_node && !(hit_now || r_found);
            end
            S_MUL3:   ln_start = (r_sel == MAP_OPACITY);
            S_FIN: begin
                emit = 1'b1;
                case (r_sel)
                    MAP_DIFFUSE, MAP_SPECULAR: begin
                        n_red   = {r_x[0][23:16], 8'h00};
                        n_green = {r_x[1][23:16], 8'h00};
                        n_blue  = {r_x[2][23:16], 8'h00};
                        if (r_sel == MAP_SPECULAR) n_alpha = {r_x[3][23:16], 8'h00};
                    end
                    MAP_EMISSIVE: begin
                        n_red   = r_y[0][55] ? 16'hFFFF : r_y[0][54:39];
                        n_green = r_y[1][55] ? 16'hFFFF : r_y[1][54:39];
                        n_blue  = r_y[2][55] ? 16'hFFFF : r_y[2][54:39];
                    end
                    default: n_alpha = ln_alpha;
                endcase
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= emit;
            if (accept && i_operation == OP_CLEAR) begin
                r_count <= '0;
            end else if (ram_we && emit) begin
                r_count <= r_count + t_count'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= n_status;
            r_red    <= n_red;
            r_green  <= n_green;
            r_blue   <= n_blue;
            r_alpha  <= n_alpha;
        end
        case (r_state)
            S_IDLE: begin
                // hold the item for the whole operation
                r_new.density           <= i_density;
                r_new.diffuse_rgb       <= i_diffuse_rgb;
                r_new.specular_rgb      <= i_specular_rgb;
                r_new.emissive_rgb      <= i_emissive_rgb;
                r_new.gloss_level       <= i_gloss_level;
                r_new.emissive_strength <= i_emissive_strength;
                r_new.optical_thickness <= i_optical_thickness;
                r_sel   <= i_map_select;
                r_idx   <= i_entry_index;
                r_wm1   <= in_wm1;
                r_found <= 1'b0;
                r_j     <= (i_operation == OP_INSERT) ? r_count : '0;
            end
            S_INS_CHK: if (shift_up) r_j <= r_j - t_count'(1);
            S_LK_CHK: begin
                if (hit_now) begin
                    r_found <= 1'b1;
                    r_lo    <= r_prev;
                    r_hi    <= ram_rdata;
                end
                r_prev   <= ram_rdata;
                r_prev_x <= cur_x;
                r_j      <= r_j + t_count'(1);
            end
            S_FRAC: begin
                r_rem <= num[24:0];
                r_den <= den;
                r_cnt <= '0;
                r_p   <= frac_zero ? 17'h00000 : 17'h10000;
            end
            S_DIV: begin
                r_rem <= div_bit ? (div_sh - {1'b0, r_den}) : div_sh;
                r_p   <= {r_p[15:0], div_bit};
                r_cnt <= r_cnt + 4'd1;
            end
            S_MUL1: begin
                for (int c = 0; c < 3; c++) begin
                    case (r_sel)
                        MAP_EMISSIVE: begin
                            r_a1[c] <= 24'(r_lo.emissive_rgb[23-8*c -: 8])
                                     * 24'(r_lo.emissive_strength);
                            r_a2[c] <= 24'(r_hi.emissive_rgb[23-8*c -: 8])
                                     * 24'(r_hi.emissive_strength);
                        end
                        MAP_SPECULAR: begin
                            r_a1[c] <= 24'(r_lo.specular_rgb[23-8*c -: 8]);
                            r_a2[c] <= 24'(r_hi.specular_rgb[23-8*c -: 8]);
                        end
                        default: begin
                            r_a1[c] <= 24'(r_lo.diffuse_rgb[23-8*c -: 8]);
                            r_a2[c] <= 24'(r_hi.diffuse_rgb[23-8*c -: 8]);
                        end
                    endcase
                end
                r_a1[3] <= (r_sel == MAP_OPACITY) ? 24'(r_lo.optical_thickness)
                                                  : 24'(r_lo.gloss_level);
                r_a2[3] <= (r_sel == MAP_OPACITY) ? 24'(r_hi.optical_thickness)
                                                  : 24'(r_hi.gloss_level);
            end
            S_MUL2: begin
                for (int c = 0; c < 4; c++) begin
                    r_x[c] <= 42'(r_a1[c]) * 42'(q) + 42'(r_a2[c]) * 42'(r_p);
                end
            end
            S_MUL3: begin
                // divide by 255 * 65536: drop 16 bits, then multiply by the reciprocal
                for (int c = 0; c < 3; c++) begin
                    r_y[c] <= 56'(r_x[c][39:16]) * 56'(RECIP_255);
                end
            end
            default: ;
        endcase
    end

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_chan_red   = r_red;
    assign o_chan_green = r_green;
    assign o_chan_blue  = r_blue;
    assign o_chan_alpha = r_alpha;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(MAX_NODES))
        else $error("node count above table size");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == OP_CLEAR) |=> (o_strobe && r_count == '0))
        else $error("clear did not empty the table in one cycle");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> (r_count == t_count'(MAX_NODES)))
        else $error("full status with room in the table");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while still working");

    a_write_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_INS_RD || r_state == S_INS_CHK))
        else $error("node RAM written outside an insert");

endmodule
`default_nettype wire

// ----- tb/sv/transfer_function_table_tb.sv -----
// Self-checking testbench of the transfer-function table: directed and random items.
`default_nettype none
module transfer_function_table_tb import tft_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Expected result of one item
    typedef struct {
        logic [1:0]  status;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } t_result;

    // One input item
    typedef struct {
        logic [1:0]  op;
        logic [16:0] density;
        logic [23:0] diffuse;
        logic [23:0] specular;
        logic [23:0] emissive;
        logic [7:0]  gloss;
        logic [15:0] strength;
        logic [15:0] thickness;
        logic [1:0]  sel;
        logic [6:0]  index;
    } t_item;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_operation = '0;
    logic [16:0] i_density = '0;
    logic [23:0] i_diffuse_rgb = '0;
    logic [23:0] i_specular_rgb = '0;
    logic [23:0] i_emissive_rgb = '0;
    logic [7:0]  i_gloss_level = '0;
    logic [15:0] i_emissive_strength = '0;
    logic [15:0] i_optical_thickness = '0;
    logic [1:0]  i_map_select = '0;
    logic [6:0]  i_entry_index = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [15:0] o_chan_red;
    logic [15:0] o_chan_green;
    logic [15:0] o_chan_blue;
    logic [15:0] o_chan_alpha;

    transfer_function_table uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the node table
    t_item   node_table[MAX_NODES];
    int      nodes_held;
    t_result expected_results[$];
    int      error_count;
    int      idle_pct;

    // Position of a node on a map: density scaled by W - 1, clamped
    function automatic longint map_pos(logic [16:0] d, longint w);
        longint x;
        x = (longint'(d) * (w - 1)) / 65536;
        return (x > w - 1) ? w - 1 : x;
    endfunction

    // -ln(1 - t) in Q8.8 from t in Q0.32, via bitwise log2 by squaring
    function automatic logic [15:0] opacity_of(logic [63:0] t);
        logic [63:0] u, m, frac, neg, r;
        int k;
        u = 64'h1_0000_0000 - t;
        k = 0;
        frac = 0;
        while (k < 32 && (u >> (k + 1)) != 0) k++;
        m = (k == 32) ? (u >> 1) : (u << (31 - k));
        for (int b = 0; b < 16; b++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        neg = (64'd32 << 16) - ((64'(k) << 16) | frac);
        r = (neg * 64'd2977044472) >> 40;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    // Apply one item to the table copy and return the result it causes
    function automatic t_result table_response(t_item it);
        t_result res;
        longint w, idx, num, den, x1, x2;
        logic [63:0] p, q, v, c1, c2, s1, s2;
        int pos, a;
        bit found;
        logic [15:0] ch[3];
        res = '{default: '0};
        case (it.op)
            OP_INSERT: begin
                if (nodes_held >= MAX_NODES) begin
                    res.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < nodes_held && node_table[pos].density <= it.density) pos++;
                    for (int j = nodes_held; j > pos; j--) node_table[j] = node_table[j - 1];
                    node_table[pos] = it;
                    nodes_held++;
                end
            end
            OP_CLEAR: nodes_held = 0;
            OP_LOOKUP: begin
                w = (it.sel == MAP_EMISSIVE) ? EMISSIVE_MAP_WIDTH : MAIN_MAP_WIDTH;
                idx = it.index;
                found = 0;
                a = 0;
                if (idx >= w) begin
                    res.status = ST_RANGE;
                    return res;
                end
                for (int j = 0; j + 1 < nodes_held; j++) begin
                    x1 = map_pos(node_table[j].density, w);
                    x2 = map_pos(node_table[j + 1].density, w);
                    if (x1 <= idx && idx <= x2) begin
                        found = 1;
                        a = j;
                    end
                end
                if (!found) return res;
                num = idx * 65536 - longint'(node_table[a].density) * (w - 1);
                den = (longint'(node_table[a + 1].density) - longint'(node_table[a].density))
                      * (w - 1);
                if (num <= 0) p = 0;
                else if (num >= den) p = 65536;
                else p = (num * 65536) / den;
                q = 65536 - p;
                for (int c = 0; c < 3; c++) begin
                    if (it.sel == MAP_EMISSIVE) begin
                        c1 = (node_table[a].emissive >> (16 - 8 * c)) & 8'hFF;
                        c2 = (node_table[a + 1].emissive >> (16 - 8 * c)) & 8'hFF;
                        s1 = node_table[a].strength;
                        s2 = node_table[a + 1].strength;
                        v = (c1 * s1 * q + c2 * s2 * p) / (64'd255 * 64'd65536);
                        ch[c] = (v > 65535) ? 16'hFFFF : v[15:0];
                    end else if (it.sel == MAP_OPACITY) begin
                        ch[c] = '0;
                    end else begin
                        c1 = (((it.sel == MAP_DIFFUSE) ? node_table[a].diffuse
                               : node_table[a].specular) >> (16 - 8 * c)) & 8'hFF;
                        c2 = (((it.sel == MAP_DIFFUSE) ? node_table[a + 1].diffuse
                               : node_table[a + 1].specular) >> (16 - 8 * c)) & 8'hFF;
                        v = ((c1 * q + c2 * p) >> 16) << 8;
                        ch[c] = v[15:0];
                    end
                end
                res.red = ch[0];
                res.green = ch[1];
                res.blue = ch[2];
                if (it.sel == MAP_SPECULAR) begin
                    v = ((64'(node_table[a].gloss) * q + 64'(node_table[a + 1].gloss) * p)
                         >> 16) << 8;
                    res.alpha = v[15:0];
                end else if (it.sel == MAP_OPACITY) begin
                    res.alpha = opacity_of(64'(node_table[a].thickness) * q
                                           + 64'(node_table[a + 1].thickness) * p);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Drive one item at the falling edge and hold it until taken
    task automatic send_item(t_item it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_operation <= it.op;
        i_density <= it.density;
        i_diffuse_rgb <= it.diffuse;
        i_specular_rgb <= it.specular;
        i_emissive_rgb <= it.emissive;
        i_gloss_level <= it.gloss;
        i_emissive_strength <= it.strength;
        i_optical_thickness <= it.thickness;
        i_map_select <= it.sel;
        i_entry_index <= it.index;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_results = {expected_results, table_response(it)};
        @(negedge i_clk);
    endtask

    function automatic t_item random_node(logic [16:0] d);
        t_item it;
        it.op = OP_INSERT;
        it.density = d;
        it.diffuse = 24'($urandom);
        it.specular = 24'($urandom);
        it.emissive = 24'($urandom);
        it.gloss = 8'($urandom);
        it.strength = 16'($urandom);
        it.thickness = 16'($urandom);
        it.sel = 2'($urandom);
        it.index = 7'($urandom);
        return it;
    endfunction

    function automatic t_item lookup_item(logic [1:0] sel, logic [6:0] index);
        t_item it;
        it = random_node(17'd0);
        it.op = OP_LOOKUP;
        it.sel = sel;
        it.index = index;
        return it;
    endfunction

    function automatic t_item op_item(logic [1:0] op);
        t_item it;
        it = random_node(17'($urandom));
        it.op = op;
        return it;
    endfunction

    // Check each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding");
                error_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    error_count++;
                end
                if (o_chan_red !== e.red) begin
                    $error("chan_red: expected %0h, got %0h", e.red, o_chan_red);
                    error_count++;
                end
                if (o_chan_green !== e.green) begin
                    $error("chan_green: expected %0h, got %0h", e.green, o_chan_green);
                    error_count++;
                end
                if (o_chan_blue !== e.blue) begin
                    $error("chan_blue: expected %0h, got %0h", e.blue, o_chan_blue);
                    error_count++;
                end
                if (o_chan_alpha !== e.alpha) begin
                    $error("chan_alpha: expected %0h, got %0h", e.alpha, o_chan_alpha);
                    error_count++;
                end
            end
        end
    end

    // Extremes: full table, overflow, clear, unused code, out-of-range indexes
    task automatic test_directed();
        send_item(op_item(OP_UNUSED));
        send_item(lookup_item(MAP_DIFFUSE, 7'd5));
        send_item(random_node(17'd0));
        send_item(lookup_item(MAP_DIFFUSE, 7'd0));
        send_item(random_node(17'h10000));
        send_item(random_node(17'h1FFFF));
        send_item(random_node(17'h10000));
        for (int s = 0; s < 4; s++) begin
            send_item(lookup_item(2'(s), 7'd0));
            send_item(lookup_item(2'(s), 7'd127));
            send_item(lookup_item(2'(s), 7'd63));
        end
        for (int n = 0; n < 13; n++) send_item(random_node(17'($urandom_range(0, 17'h1FFFF))));
        send_item(random_node(17'd100));
        send_item(op_item(OP_CLEAR));
    endtask

    // Build a fresh table, then run a burst of mostly lookups, mixed with other operations, against it
    task automatic test_random_tables(int pct, int items);
        t_item n;
        int count, sent;
        idle_pct = pct;
        sent = 0;
        while (sent < items) begin
            send_item(op_item(OP_CLEAR));
            count = $urandom_range(0, 17);
            for (int k = 0; k < count; k++) begin
                case ($urandom_range(5))
                    0: n = random_node(17'($urandom_range(0, 17'h1FFFF)));
                    1: n = random_node(17'($urandom_range(0, 4) * 16384));
                    default: n = random_node(17'($urandom_range(0, 65536)));
                endcase
                // thickness near one drives the log toward saturation
                if ($urandom_range(7) == 0) n.thickness = 16'(16'hFFFF - $urandom_range(3));
                send_item(n);
            end
            for (int k = 0; k < 24; k++) begin
                if ($urandom_range(19) == 0) send_item(op_item(2'($urandom_range(0, 3))));
                else send_item(lookup_item(2'($urandom), 7'($urandom)));
            end
            sent += count + 25;
        end
    endtask

    initial begin
        error_count = 0;
        nodes_held = 0;
        idle_pct = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_tables(0, 350);
        test_random_tables(47, 350);
        test_random_tables(47, 350);
        test_random_tables(23, 350);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hold a generous ceiling on run time
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
